@@ rtl/md5_pkg.sv @@
// shared types, constants and round functions of the md5 engine
package md5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [5:0] LEN_START_POS = 6'd56;
  localparam logic [5:0] LAST_POS      = 6'd63;
  localparam logic [5:0] LAST_ROUND    = 6'd63;

  typedef enum logic [1:0] {
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN
  } pad_kind_t;

  typedef struct packed {
    logic      put;
    logic      sel_pad;
    pad_kind_t pad_kind;
    logic      add_bits;
    logic      load_work;
    logic      round_en;
    logic [5:0] round_idx;
    logic [5:0] rd_idx;
    logic      finish;
    logic      init;
    logic      out_part;
  } md5_cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_len_start;
  } md5_status_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'd3614090360, 32'd3905402710, 32'd606105819,  32'd3250441966,
    32'd4118548399, 32'd1200080426, 32'd2821735955, 32'd4249261313,
    32'd1770035416, 32'd2336552879, 32'd4294925233, 32'd2304563134,
    32'd1804603682, 32'd4254626195, 32'd2792965006, 32'd1236535329,
    32'd4129170786, 32'd3225465664, 32'd643717713,  32'd3921069994,
    32'd3593408605, 32'd38016083,   32'd3634488961, 32'd3889429448,
    32'd568446438,  32'd3275163606, 32'd4107603335, 32'd1163531501,
    32'd2850285829, 32'd4243563512, 32'd1735328473, 32'd2368359562,
    32'd4294588738, 32'd2272392833, 32'd1839030562, 32'd4259657740,
    32'd2763975236, 32'd1272893353, 32'd4139469664, 32'd3200236656,
    32'd681279174,  32'd3936430074, 32'd3572445317, 32'd76029189,
    32'd3654602809, 32'd3873151461, 32'd530742520,  32'd3299628645,
    32'd4096336452, 32'd1126891415, 32'd2878612391, 32'd4237533241,
    32'd1700485571, 32'd2399980690, 32'd4293915773, 32'd2240044497,
    32'd1873313359, 32'd4264355552, 32'd2734768916, 32'd1309151649,
    32'd4149444226, 32'd3174756917, 32'd718787259,  32'd3951481745
  };

  // rotate amounts indexed by {quarter, step mod 4}
  localparam logic [4:0] ROT_S [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  // message word index used in a given round
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] g;
    logic [3:0] lo;
    lo = r[3:0];
    unique case (r[5:4])
      2'd0: g = lo;
      2'd1: g = 4'(lo * 4'd5 + 4'd1);
      2'd2: g = 4'(lo * 4'd3 + 4'd5);
      2'd3: g = 4'(lo * 4'd7);
      default: g = lo;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_f(input logic [1:0] q, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (q)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

@@ rtl/md5_digest_engine_core.sv @@
// top level of the md5 digest engine
// Input channel (in_valid/in_ready) takes one word per item: data_byte,
// has_byte, end_of_message. Output channel (out_valid/out_ready) gives the
// 128-bit digest as two words: part_index 0 carries digest bytes 0-7, part
// index 1 carries bytes 8-15 with last_part set; byte 0 sits in bits 7:0.
// An item without end_of_message that does not complete a 64-byte block
// leaves in_ready high. An item that completes a block holds in_ready low
// while the engine loads the working words, runs 64 rounds at one round per
// cycle through the single round unit and folds them into the chaining words.
// End of message: padding writes one byte per cycle into the block buffer up
// to the end of the block, plus one more block when pos is 56 or above, pos
// being the fill after the last byte; each completed block is compressed as
// above, then the two digest words follow.
// in_ready stays low while the digest waits; a stalled receiver simply holds
// the engine. After the second word is taken the engine returns to the
// initial chaining values for the next message.
// Reset (synchronous, active high) restores the initial chaining values and
// clears the byte position and bit count; the block buffer has no reset.
module md5_digest_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_part,
  output logic        part_index,
  output logic        last_part
);

  md5_pkg::md5_cmd_t    cmd;
  md5_pkg::md5_status_t status;

  md5_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .cmd            (cmd)
  );

  md5_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .status      (status),
    .digest_part (digest_part),
    .part_index  (part_index),
    .last_part   (last_part)
  );

endmodule

@@ rtl/md5_datapath.sv @@
// block buffer, chaining words, round datapath and length counter
module md5_datapath (
  input  logic                clk,
  input  logic                rst,
  input  md5_pkg::md5_cmd_t   cmd,
  input  logic [7:0]          data_byte,
  output md5_pkg::md5_status_t status,
  output logic [63:0]         digest_part,
  output logic                part_index,
  output logic                last_part
);

  logic [31:0] mem [16];
  logic [31:0] w_rd;

  logic [5:0]  pos;
  logic [63:0] bit_count;
  logic [31:0] cw [4];
  logic [31:0] a, b, c, d;

  logic [7:0]  pad_byte;
  logic [7:0]  wr_byte;
  logic [3:0]  s_idx;
  logic [31:0] sum;
  logic [31:0] b_next;

  always_comb begin
    unique case (cmd.pad_kind)
      md5_pkg::PAD_MARK: pad_byte = md5_pkg::PAD_MARK_BYTE;
      md5_pkg::PAD_LEN:  pad_byte = bit_count[{pos[2:0], 3'b000} +: 8];
      default:           pad_byte = 8'h00;
    endcase
    wr_byte = cmd.sel_pad ? pad_byte : data_byte;
  end

  // byte-lane writes into 32-bit words, registered word read
  always_ff @(posedge clk) begin
    if (cmd.put) begin
      mem[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= wr_byte;
    end
    w_rd <= mem[md5_pkg::msg_index(cmd.rd_idx)];
  end

  assign s_idx  = {cmd.round_idx[5:4], cmd.round_idx[1:0]};
  assign sum    = a + md5_pkg::round_f(cmd.round_idx[5:4], b, c, d)
                + md5_pkg::ROUND_K[cmd.round_idx] + w_rd;
  assign b_next = b + md5_pkg::rotl32(sum, md5_pkg::ROT_S[s_idx]);

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      pos       <= '0;
      bit_count <= '0;
      cw[0]     <= md5_pkg::IV_A;
      cw[1]     <= md5_pkg::IV_B;
      cw[2]     <= md5_pkg::IV_C;
      cw[3]     <= md5_pkg::IV_D;
    end else begin
      if (cmd.put) begin
        pos <= pos + 6'd1;
      end
      if (cmd.add_bits) begin
        bit_count <= bit_count + 64'd8;
      end
      if (cmd.finish) begin
        cw[0] <= cw[0] + a;
        cw[1] <= cw[1] + b;
        cw[2] <= cw[2] + c;
        cw[3] <= cw[3] + d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      a <= cw[0];
      b <= cw[1];
      c <= cw[2];
      d <= cw[3];
    end else if (cmd.round_en) begin
      a <= d;
      d <= c;
      c <= b;
      b <= b_next;
    end
  end

  assign status.pos_last      = (pos == md5_pkg::LAST_POS);
  assign status.pos_len_start = (pos == md5_pkg::LEN_START_POS);

  assign digest_part = cmd.out_part ? {cw[3], cw[2]} : {cw[1], cw[0]};
  assign part_index  = cmd.out_part;
  assign last_part   = cmd.out_part;

endmodule

@@ rtl/md5_ctrl.sv @@
// sequencer: byte intake, padding, compression rounds and digest output
module md5_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 has_byte,
  input  logic                 end_of_message,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  md5_pkg::md5_status_t status,
  output md5_pkg::md5_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LOAD,
    S_ROUND,
    S_FINAL,
    S_OUT0,
    S_OUT1
  } state_t;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_PAD,
    RET_OUT
  } ret_t;

  state_t     state, state_next;
  ret_t       ret, ret_next;
  logic       first, first_next;
  logic       len_phase, len_phase_next;
  logic [5:0] round_cnt, round_cnt_next;
  logic       len_byte;

  always_comb begin
    state_next     = state;
    ret_next       = ret;
    first_next     = first;
    len_phase_next = len_phase;
    round_cnt_next = round_cnt;
    len_byte       = len_phase || (!first && status.pos_len_start);

    cmd           = '0;
    cmd.pad_kind  = md5_pkg::PAD_ZERO;
    cmd.round_idx = round_cnt;
    cmd.rd_idx    = round_cnt + 6'd1;
    cmd.out_part  = (state == S_OUT1);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.put      = has_byte;
          cmd.add_bits = has_byte;
          first_next     = 1'b1;
          len_phase_next = 1'b0;
          if (has_byte && status.pos_last) begin
            ret_next   = end_of_message ? RET_PAD : RET_IDLE;
            state_next = S_LOAD;
          end else if (end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd.put     = 1'b1;
        cmd.sel_pad = 1'b1;
        if (first) begin
          cmd.pad_kind = md5_pkg::PAD_MARK;
        end else if (len_byte) begin
          cmd.pad_kind = md5_pkg::PAD_LEN;
        end
        first_next     = 1'b0;
        len_phase_next = len_byte;
        if (status.pos_last) begin
          // last length byte closes the message; any other byte here starts another padding block
          ret_next   = (!first && len_byte) ? RET_OUT : RET_PAD;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_work  = 1'b1;
        cmd.rd_idx     = '0;
        round_cnt_next = '0;
        state_next     = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en   = 1'b1;
        round_cnt_next = round_cnt + 6'd1;
        if (round_cnt == md5_pkg::LAST_ROUND) begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        cmd.finish = 1'b1;
        unique case (ret)
          RET_PAD: state_next = S_PAD;
          RET_OUT: state_next = S_OUT0;
          default: state_next = S_IDLE;
        endcase
      end
      S_OUT0: begin
        if (out_ready) begin
          state_next = S_OUT1;
        end
      end
      S_OUT1: begin
        if (out_ready) begin
          cmd.init   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= RET_IDLE;
      first     <= 1'b0;
      len_phase <= 1'b0;
      round_cnt <= '0;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      first     <= first_next;
      len_phase <= len_phase_next;
      round_cnt <= round_cnt_next;
      in_ready  <= (state_next == S_IDLE);
      out_valid <= (state_next == S_OUT0) || (state_next == S_OUT1);
    end
  end

endmodule

@@ test/tb.sv @@
// self-checking testbench for the md5 digest engine: byte stream in, digest words out
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_TAIL   = 300;
  localparam int STALL_CYCLES = 600;

  localparam logic [31:0] INIT_A   = 32'h67452301;
  localparam logic [31:0] INIT_B   = 32'hefcdab89;
  localparam logic [31:0] INIT_C   = 32'h98badcfe;
  localparam logic [31:0] INIT_D   = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS  = 6'd56;

  localparam logic [31:0] SINE_K [64] = '{
    32'd3614090360, 32'd3905402710, 32'd606105819,  32'd3250441966,
    32'd4118548399, 32'd1200080426, 32'd2821735955, 32'd4249261313,
    32'd1770035416, 32'd2336552879, 32'd4294925233, 32'd2304563134,
    32'd1804603682, 32'd4254626195, 32'd2792965006, 32'd1236535329,
    32'd4129170786, 32'd3225465664, 32'd643717713,  32'd3921069994,
    32'd3593408605, 32'd38016083,   32'd3634488961, 32'd3889429448,
    32'd568446438,  32'd3275163606, 32'd4107603335, 32'd1163531501,
    32'd2850285829, 32'd4243563512, 32'd1735328473, 32'd2368359562,
    32'd4294588738, 32'd2272392833, 32'd1839030562, 32'd4259657740,
    32'd2763975236, 32'd1272893353, 32'd4139469664, 32'd3200236656,
    32'd681279174,  32'd3936430074, 32'd3572445317, 32'd76029189,
    32'd3654602809, 32'd3873151461, 32'd530742520,  32'd3299628645,
    32'd4096336452, 32'd1126891415, 32'd2878612391, 32'd4237533241,
    32'd1700485571, 32'd2399980690, 32'd4293915773, 32'd2240044497,
    32'd1873313359, 32'd4264355552, 32'd2734768916, 32'd1309151649,
    32'd4149444226, 32'd3174756917, 32'd718787259,  32'd3951481745
  };

  localparam int SHIFT_S [16] = '{
    7, 12, 17, 22,
    5, 9, 14, 20,
    4, 11, 16, 23,
    6, 10, 15, 21
  };

  // lengths around the one-block / two-block padding boundaries
  localparam int EDGE_LENS [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  typedef struct packed {
    logic [63:0] part;
    logic        idx;
    logic        last;
  } digest_word_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] digest_part;
  logic        part_index;
  logic        last_part;

  // predictor state
  logic [31:0] hash_h [4];
  logic [7:0]  msg_block [64];
  logic [5:0]  fill_pos;
  logic [63:0] msg_bits;

  digest_word_t digest_q [$];

  int fail_count    = 0;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int hold_left     = 0;

  md5_digest_engine_core u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .has_byte       (has_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digest_part    (digest_part),
    .part_index     (part_index),
    .last_part      (last_part)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] rol32(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic restart_chain();
    hash_h[0] = INIT_A;
    hash_h[1] = INIT_B;
    hash_h[2] = INIT_C;
    hash_h[3] = INIT_D;
    fill_pos  = '0;
    msg_bits  = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int i, g, q;
    for (i = 0; i < 16; i++)
      w[i] = {msg_block[4*i+3], msg_block[4*i+2], msg_block[4*i+1], msg_block[4*i]};
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    for (i = 0; i < 64; i++) begin
      q = i / 16;
      case (q)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rol32(a + f + SINE_K[i] + w[g], SHIFT_S[q * 4 + i % 4]);
      a = t;
    end
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
  endtask

  task automatic put_byte(input logic [7:0] v);
    msg_block[fill_pos] = v;
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) compress_block();
  endtask

  // fold one accepted word into the running hash, queue the digest at end of message
  task automatic md5_absorb(input logic [7:0] b, input logic hb, input logic eom);
    logic [63:0] len;
    int k;
    if (hb) begin
      put_byte(b);
      msg_bits += 64'd8;
    end
    if (eom) begin
      len = msg_bits;
      put_byte(PAD_BYTE);
      while (fill_pos != LEN_POS) put_byte(8'h00);
      for (k = 0; k < 8; k++) put_byte(len[8*k +: 8]);
      digest_q.push_back('{part: {hash_h[1], hash_h[0]}, idx: 1'b0, last: 1'b0});
      digest_q.push_back('{part: {hash_h[3], hash_h[2]}, idx: 1'b1, last: 1'b1});
      restart_chain();
    end
  endtask

  // called and returns at a falling edge; valid stays up until the next call or set_idling
  task automatic send_word(input logic [7:0] b, input logic hb, input logic eom);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    has_byte       <= hb;
    end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    md5_absorb(b, hb, eom);
    @(negedge clk);
  endtask

  // drop valid, then change the idling mix at a rising edge so the receiver sees it cleanly
  task automatic set_idling(input int send_pct, input int recv_pct, input int hold);
    in_valid <= 1'b0;
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    hold_request  = hold;
    @(negedge clk);
  endtask

  task automatic test_directed();
    // empty message straight out of reset
    send_word(8'h00, 1'b0, 1'b1);
    // neither byte nor end: ignored
    send_word(8'hff, 1'b0, 1'b0);
    // "abc" with end on the last byte
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b1);
    // byte extremes, an ignored word, end on its own with junk in data_byte, then a one-byte message
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hff, 1'b1, 1'b0);
    send_word(8'ha5, 1'b0, 1'b0);
    send_word(8'h5a, 1'b0, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
  endtask

  task automatic test_random_messages(input int min_words, input int min_msgs);
    int words, msgs, len, pick, i;
    bit sep_end;
    words = 0;
    msgs  = 0;
    while (words < min_words || msgs < min_msgs) begin
      pick = $urandom_range(99);
      if (pick < 25) len = EDGE_LENS[$urandom_range(11)];
      else if (pick < 85) len = $urandom_range(70);
      else len = $urandom_range(300, 71);
      sep_end = (len == 0) || ($urandom_range(1) == 1);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(19) == 0) send_word(8'($urandom), 1'b0, 1'b0);
        send_word(8'($urandom), 1'b1, !sep_end && (i == len - 1));
        words++;
      end
      if (sep_end) begin
        send_word(8'($urandom), 1'b0, 1'b1);
        words++;
      end
      msgs++;
    end
  endtask

  // receiver holds off long enough that a pending digest blocks the input side
  task automatic test_output_stall();
    int m, j;
    set_idling(0, 0, STALL_CYCLES);
    for (m = 0; m < 4; m++)
      for (j = 0; j < 3; j++) send_word(8'($urandom), 1'b1, j == 2);
  endtask

  // receiver
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // digest word checker
  always @(posedge clk) begin
    digest_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        $error("digest word with none pending: digest_part %h", digest_part);
        fail_count++;
      end else begin
        want = digest_q.pop_front();
        if (digest_part !== want.part) begin
          $error("digest_part expected %h actual %h", want.part, digest_part);
          fail_count++;
        end
        if (part_index !== want.idx) begin
          $error("part_index expected %0b actual %0b", want.idx, part_index);
          fail_count++;
        end
        if (last_part !== want.last) begin
          $error("last_part expected %0b actual %0b", want.last, last_part);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL md5_digest_engine_core");
        $finish;
      end
    end
  end

  initial begin
    restart_chain();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    set_idling(23, 85, 0);
    test_random_messages(350, 4);
    set_idling(85, 23, 0);
    test_random_messages(350, 4);
    set_idling(0, 0, 0);
    test_random_messages(350, 4);
    test_output_stall();
    set_idling(0, 0, 0);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS md5_digest_engine_core");
    end else begin
      $display("FAIL md5_digest_engine_core");
    end
    $finish;
  end

endmodule
